### src/bomx_pkg.sv
// Shared constants, command codes and request/result types of the bond order engine.
package bomx_pkg;

  localparam int MAX_BASIS     = 64;
  localparam int MAX_ATOMS     = 32;
  localparam int FRACTION_BITS = 28;

  localparam int BI_W   = $clog2(MAX_BASIS);       // basis index bits
  localparam int AI_W   = $clog2(MAX_ATOMS);       // atom index bits
  localparam int BC_W   = $clog2(MAX_BASIS + 1);   // basis count bits
  localparam int AC_W   = $clog2(MAX_ATOMS + 1);   // atom count bits
  localparam int MAT_W  = 32;                      // density and overlap entries
  localparam int PS_W   = 40;                      // product entries
  localparam int BOND_W = 48;                      // bond entries
  localparam int MP_W   = 2 * MAT_W;               // full matrix term
  localparam int TERM_W = MP_W - FRACTION_BITS;    // shifted matrix term
  localparam int ACC_W  = TERM_W + BI_W + 1;       // dot product accumulator
  localparam int SPLIT  = PS_W / 2;                // low half of the split operand
  localparam int PP_W   = PS_W + SPLIT + 1;        // one partial product
  localparam int FULL_W = PP_W + SPLIT;            // recombined pair product
  localparam int PT_W   = FULL_W - FRACTION_BITS;  // shifted pair term

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATOMS = 1'd1;

  localparam logic [2:0] CMD_LOAD_P   = 3'd0;
  localparam logic [2:0] CMD_LOAD_S   = 3'd1;
  localparam logic [2:0] CMD_LOAD_OWN = 3'd2;
  localparam logic [2:0] CMD_COMPUTE  = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;

  typedef struct packed {
    logic [2:0]        command;
    logic [5:0]        row;
    logic [5:0]        col;
    logic signed [31:0] matrix_value;
    logic [4:0]        owner_atom;
    logic [4:0]        pair_first;
    logic [4:0]        pair_second;
  } in_req_t;

  typedef struct packed {
    logic signed [47:0] bond_order;
    logic               saturated;
  } out_res_t;

  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last;
    logic [BI_W-1:0] mu;
    logic [BI_W-1:0] nu;
  } mm_tag_t;

endpackage

### src/bomx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bomx_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write and read ports, read data held when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/bond_order_matrix_engine.sv
// Top level of the bond order engine: command decode, matrix walk and pair accumulation.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  in      | start, busy, in_req                     | taken when start && !busy
//  out     | out_valid, out_res                      | one-cycle strobe, no back-pressure
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | taken when valid && ready
//
// Loads and reads are accepted while idle; a read result shows in the next cycle.
// A compute holds busy through the multiply pipeline over the density and overlap
// memories, a pass clearing all 1024 pair memory entries, and the read-modify-write
// accumulation on the pair memory.
// Reset is synchronous; the results cannot be stalled.
module bond_order_matrix_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  bomx_pkg::in_req_t                   in_req,
  output logic                                out_valid,
  output bomx_pkg::out_res_t                  out_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bomx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bomx_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int BI = bomx_pkg::BI_W;
  localparam int AI = bomx_pkg::AI_W;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_MM       = 12'b000000000010,
    ST_DRAIN    = 12'b000000000100,
    ST_CLR      = 12'b000000001000,
    ST_OWN      = 12'b000000010000,
    ST_OWN_CHK  = 12'b000000100000,
    ST_PR_ISSUE = 12'b000001000000,
    ST_PR_DATA  = 12'b000010000000,
    ST_MUL_HI   = 12'b000100000000,
    ST_MUL_LO   = 12'b001000000000,
    ST_SUM      = 12'b010000000000,
    ST_ACC      = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [bomx_pkg::BC_W-1:0] basis_r;
  logic [bomx_pkg::AC_W-1:0] atoms_r;
  logic [bomx_pkg::BC_W-1:0] n_used;
  logic [bomx_pkg::AC_W-1:0] na_used;
  logic [BI-1:0] mu_r, mu_nxt, nu_r, nu_nxt, k_r, k_nxt;
  logic [AI+AI-1:0] clr_r, clr_nxt;
  logic [AI-1:0] ai_r, ai_nxt, aj_r, aj_nxt;
  logic computed_r, out_valid_r, rd_ok_r;
  logic accept;
  logic mu_last, nu_last, k_last;

  bomx_pkg::mm_tag_t tag_a_r, tag_a_nxt, tag_b_r, tag_c_r;
  logic signed [bomx_pkg::MP_W-1:0]   prod_r;
  logic signed [bomx_pkg::ACC_W-1:0]  acc_r;
  logic signed [bomx_pkg::TERM_W-1:0] term;
  logic ps_sat;
  logic [bomx_pkg::PS_W-1:0] ps_sat_val;

  logic signed [bomx_pkg::PP_W-1:0]   pp;
  logic signed [bomx_pkg::SPLIT:0]    op2;
  logic signed [bomx_pkg::PP_W-1:0]   ph_r, pl_r;
  logic signed [bomx_pkg::FULL_W-1:0] full;
  logic signed [bomx_pkg::PT_W-1:0]   pt_r;
  logic signed [bomx_pkg::PT_W:0]     bsum;
  logic bsum_ovf;

  // memory ports
  logic [bomx_pkg::MAT_W-1:0] p_rd, s_rd;
  logic [bomx_pkg::PS_W:0]    psa_rd, psb_rd, ps_wdata;
  logic [AI-1:0]              own_rd;
  logic [bomx_pkg::BOND_W:0]  bond_rd, bond_wdata;
  logic [2*BI-1:0] ps_waddr;
  logic            ps_we, own_re, bond_we, bond_re;
  logic [BI-1:0]   own_raddr;
  logic [2*AI-1:0] bond_waddr, bond_raddr;
  logic            rd_in_range;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // clamp the configured dimensions
  always_comb begin
    if (basis_r == '0) begin
      n_used = bomx_pkg::BC_W'(1);
    end else if (basis_r > bomx_pkg::BC_W'(bomx_pkg::MAX_BASIS)) begin
      n_used = bomx_pkg::BC_W'(bomx_pkg::MAX_BASIS);
    end else begin
      n_used = basis_r;
    end
    if (atoms_r == '0) begin
      na_used = bomx_pkg::AC_W'(1);
    end else if (atoms_r > bomx_pkg::AC_W'(bomx_pkg::MAX_ATOMS)) begin
      na_used = bomx_pkg::AC_W'(bomx_pkg::MAX_ATOMS);
    end else begin
      na_used = atoms_r;
    end
  end

  assign mu_last = ({1'b0, mu_r} == n_used - 1'b1);
  assign nu_last = ({1'b0, nu_r} == n_used - 1'b1);
  assign k_last  = ({1'b0, k_r} == n_used - 1'b1);
  assign rd_in_range = ({1'b0, in_req.pair_first} < na_used) &&
                       ({1'b0, in_req.pair_second} < na_used);

  // matrix stores
  bomx_ram #(.W(bomx_pkg::MAT_W), .D(bomx_pkg::MAX_BASIS * bomx_pkg::MAX_BASIS)) u_dens (
    .clk, .we(accept && in_req.command == bomx_pkg::CMD_LOAD_P),
    .waddr({in_req.row, in_req.col}), .wdata(in_req.matrix_value),
    .re(state_r == ST_MM), .raddr({mu_r, k_r}), .rdata(p_rd));

  bomx_ram #(.W(bomx_pkg::MAT_W), .D(bomx_pkg::MAX_BASIS * bomx_pkg::MAX_BASIS)) u_ovl (
    .clk, .we(accept && in_req.command == bomx_pkg::CMD_LOAD_S),
    .waddr({in_req.row, in_req.col}), .wdata(in_req.matrix_value),
    .re(state_r == ST_MM), .raddr({k_r, nu_r}), .rdata(s_rd));

  // two copies of the product store so both transposed entries read at once
  bomx_ram #(.W(bomx_pkg::PS_W + 1), .D(bomx_pkg::MAX_BASIS * bomx_pkg::MAX_BASIS)) u_psa (
    .clk, .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .re(state_r == ST_PR_ISSUE), .raddr({mu_r, nu_r}), .rdata(psa_rd));

  bomx_ram #(.W(bomx_pkg::PS_W + 1), .D(bomx_pkg::MAX_BASIS * bomx_pkg::MAX_BASIS)) u_psb (
    .clk, .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .re(state_r == ST_PR_ISSUE), .raddr({nu_r, mu_r}), .rdata(psb_rd));

  assign own_re    = (state_r == ST_OWN) || (state_r == ST_PR_ISSUE);
  assign own_raddr = (state_r == ST_OWN) ? mu_r : nu_r;

  bomx_ram #(.W(AI), .D(bomx_pkg::MAX_BASIS)) u_own (
    .clk, .we(accept && in_req.command == bomx_pkg::CMD_LOAD_OWN),
    .waddr(in_req.row), .wdata(in_req.owner_atom),
    .re(own_re), .raddr(own_raddr), .rdata(own_rd));

  assign bond_re    = (state_r == ST_PR_DATA) || accept;
  assign bond_raddr = (state_r == ST_PR_DATA) ? {ai_r, own_rd}
                                              : {in_req.pair_first, in_req.pair_second};

  bomx_ram #(.W(bomx_pkg::BOND_W + 1), .D(bomx_pkg::MAX_ATOMS * bomx_pkg::MAX_ATOMS)) u_bond (
    .clk, .we(bond_we), .waddr(bond_waddr), .wdata(bond_wdata),
    .re(bond_re), .raddr(bond_raddr), .rdata(bond_rd));

  // dot product pipeline: scale each term, accumulate, saturate on the last term
  assign term = prod_r[bomx_pkg::MP_W-1:bomx_pkg::FRACTION_BITS];
  assign ps_sat = (acc_r[bomx_pkg::ACC_W-1:bomx_pkg::PS_W-1] != '0) &&
                  (acc_r[bomx_pkg::ACC_W-1:bomx_pkg::PS_W-1] != '1);
  always_comb begin
    if (!ps_sat) begin
      ps_sat_val = acc_r[bomx_pkg::PS_W-1:0];
    end else if (acc_r[bomx_pkg::ACC_W-1]) begin
      ps_sat_val = {1'b1, {(bomx_pkg::PS_W-1){1'b0}}};
    end else begin
      ps_sat_val = {1'b0, {(bomx_pkg::PS_W-1){1'b1}}};
    end
  end
  assign ps_we    = tag_c_r.valid && tag_c_r.last;
  assign ps_waddr = {tag_c_r.mu, tag_c_r.nu};
  assign ps_wdata = {ps_sat, ps_sat_val};

  // pair product: one shared multiplier over the high and low halves of PS(nu,mu)
  assign op2 = (state_r == ST_MUL_HI) ?
               $signed({psb_rd[bomx_pkg::PS_W-1], psb_rd[bomx_pkg::PS_W-1:bomx_pkg::SPLIT]}) :
               $signed({1'b0, psb_rd[bomx_pkg::SPLIT-1:0]});
  assign pp   = $signed(psa_rd[bomx_pkg::PS_W-1:0]) * op2;
  assign full = $signed({ph_r, {bomx_pkg::SPLIT{1'b0}}}) +
                bomx_pkg::FULL_W'(pl_r);
  assign bsum = (bomx_pkg::PT_W + 1)'($signed(bond_rd[bomx_pkg::BOND_W-1:0])) +
                (bomx_pkg::PT_W + 1)'(pt_r);
  assign bsum_ovf = (bsum[bomx_pkg::PT_W:bomx_pkg::BOND_W-1] != '0) &&
                    (bsum[bomx_pkg::PT_W:bomx_pkg::BOND_W-1] != '1);

  // pair memory write: clearing pass or accumulated entry
  always_comb begin
    bond_we    = 1'b0;
    bond_waddr = clr_r;
    bond_wdata = '0;
    if (state_r == ST_CLR) begin
      bond_we = 1'b1;
    end else if (state_r == ST_ACC) begin
      bond_we    = 1'b1;
      bond_waddr = {ai_r, aj_r};
      bond_wdata[bomx_pkg::BOND_W] = bond_rd[bomx_pkg::BOND_W] || psa_rd[bomx_pkg::PS_W] ||
                                     psb_rd[bomx_pkg::PS_W] || bsum_ovf;
      if (!bsum_ovf) begin
        bond_wdata[bomx_pkg::BOND_W-1:0] = bsum[bomx_pkg::BOND_W-1:0];
      end else if (bsum[bomx_pkg::PT_W]) begin
        bond_wdata[bomx_pkg::BOND_W-1:0] = {1'b1, {(bomx_pkg::BOND_W-1){1'b0}}};
      end else begin
        bond_wdata[bomx_pkg::BOND_W-1:0] = {1'b0, {(bomx_pkg::BOND_W-1){1'b1}}};
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mu_nxt    = mu_r;
    nu_nxt    = nu_r;
    k_nxt     = k_r;
    clr_nxt   = clr_r;
    ai_nxt    = ai_r;
    aj_nxt    = aj_r;
    tag_a_nxt = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_req.command == bomx_pkg::CMD_COMPUTE) begin
          mu_nxt    = '0;
          nu_nxt    = '0;
          k_nxt     = '0;
          state_nxt = ST_MM;
        end
      end
      ST_MM: begin
        tag_a_nxt = '{valid: 1'b1, first: (k_r == '0), last: k_last, mu: mu_r, nu: nu_r};
        k_nxt = k_r + 1'b1;
        if (k_last) begin
          k_nxt  = '0;
          nu_nxt = nu_r + 1'b1;
          if (nu_last) begin
            nu_nxt = '0;
            mu_nxt = mu_r + 1'b1;
            if (mu_last) begin
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!tag_a_r.valid && !tag_b_r.valid && !tag_c_r.valid) begin
          clr_nxt   = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          mu_nxt    = '0;
          state_nxt = ST_OWN;
        end
      end
      ST_OWN: begin
        state_nxt = ST_OWN_CHK;
      end
      ST_OWN_CHK: begin
        ai_nxt = own_rd;
        nu_nxt = '0;
        if ({1'b0, own_rd} < na_used) begin
          state_nxt = ST_PR_ISSUE;
        end else if (mu_last) begin
          state_nxt = ST_IDLE;
        end else begin
          mu_nxt    = mu_r + 1'b1;
          state_nxt = ST_OWN;
        end
      end
      ST_PR_ISSUE: begin
        state_nxt = ST_PR_DATA;
      end
      ST_PR_DATA: begin
        aj_nxt = own_rd;
        if (({1'b0, own_rd} < na_used) && (own_rd != ai_r)) begin
          state_nxt = ST_MUL_HI;
        end else if (!nu_last) begin
          nu_nxt    = nu_r + 1'b1;
          state_nxt = ST_PR_ISSUE;
        end else if (mu_last) begin
          state_nxt = ST_IDLE;
        end else begin
          mu_nxt    = mu_r + 1'b1;
          state_nxt = ST_OWN;
        end
      end
      ST_MUL_HI: begin
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (!nu_last) begin
          nu_nxt    = nu_r + 1'b1;
          state_nxt = ST_PR_ISSUE;
        end else if (mu_last) begin
          state_nxt = ST_IDLE;
        end else begin
          mu_nxt    = mu_r + 1'b1;
          state_nxt = ST_OWN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      basis_r     <= bomx_pkg::BC_W'(1);
      atoms_r     <= bomx_pkg::AC_W'(1);
      computed_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tag_a_r     <= '0;
      tag_b_r     <= '0;
      tag_c_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      tag_a_r     <= tag_a_nxt;
      tag_b_r     <= tag_a_r;
      tag_c_r     <= tag_b_r;
      out_valid_r <= accept && in_req.command == bomx_pkg::CMD_READ;
      if (accept && in_req.command == bomx_pkg::CMD_COMPUTE) begin
        computed_r <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bomx_pkg::CFG_BASIS: basis_r <= cfg_data[bomx_pkg::BC_W-1:0];
          bomx_pkg::CFG_ATOMS: atoms_r <= cfg_data[bomx_pkg::AC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mu_r    <= mu_nxt;
    nu_r    <= nu_nxt;
    k_r     <= k_nxt;
    clr_r   <= clr_nxt;
    ai_r    <= ai_nxt;
    aj_r    <= aj_nxt;
    prod_r  <= $signed(p_rd) * $signed(s_rd);
    rd_ok_r <= rd_in_range && computed_r;
    if (tag_b_r.valid) begin
      acc_r <= (tag_b_r.first ? '0 : acc_r) + bomx_pkg::ACC_W'(term);
    end
    if (state_r == ST_MUL_HI) begin
      ph_r <= pp;
    end
    if (state_r == ST_MUL_LO) begin
      pl_r <= pp;
    end
    if (state_r == ST_SUM) begin
      pt_r <= full[bomx_pkg::FULL_W-1:bomx_pkg::FRACTION_BITS];
    end
  end

  // read result
  assign out_valid          = out_valid_r;
  assign out_res.bond_order = rd_ok_r ? $signed(bond_rd[bomx_pkg::BOND_W-1:0]) : '0;
  assign out_res.saturated  = rd_ok_r && bond_rd[bomx_pkg::BOND_W];

endmodule

### src/bomx_chk.sv
// Port-level checker for the bond order engine, bound to the top level.
module bomx_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input bomx_pkg::in_req_t  in_req,
  input logic               out_valid
);

  // a result comes in the cycle after a read request
  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_req.command == bomx_pkg::CMD_READ))
    else $error("result without read request");

  // every read request gives a result
  a_read_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.command == bomx_pkg::CMD_READ) |=> out_valid)
    else $error("read request lost");

  // only a compute request raises busy
  a_busy_from_compute: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_req.command == bomx_pkg::CMD_COMPUTE))
    else $error("busy without compute");

  // results never appear during a compute
  a_no_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

endmodule

bind bond_order_matrix_engine bomx_chk u_bomx_chk (
  .clk, .rst_n, .start, .busy, .in_req, .out_valid);
